// ----- rtl/core/half_duplex_block_link_control_macros.svh -----
`ifndef HALF_DUPLEX_BLOCK_LINK_CONTROL_MACROS_SVH
`define HALF_DUPLEX_BLOCK_LINK_CONTROL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HDBL_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("link control check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HDBL_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("link control check failed");

`endif

// ----- rtl/core/hdbl_pkg.sv -----
package hdbl_pkg;

   localparam logic [7:0] CH_ENQ = 8'h05;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;

   localparam logic [7:0] MIN_BLOCK_LEN = 8'd10;
   localparam int         HIGH_SHIFT    = 8;

   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;
   localparam logic [3:0] COUNT_MAX         = 4'hF;

   localparam logic [1:0] OP_SEND    = 2'd0;
   localparam logic [1:0] OP_BYTE    = 2'd1;
   localparam logic [1:0] OP_TIMER   = 2'd2;
   localparam logic [1:0] OP_INVALID = 2'd3;

   localparam logic [1:0] PH_IDLE       = 2'd0;
   localparam logic [1:0] PH_WAIT_EOT   = 2'd1;
   localparam logic [1:0] PH_WAIT_BLOCK = 2'd2;
   localparam logic [1:0] PH_WAIT_CHECK = 2'd3;

   localparam logic [1:0] RX_LENGTH   = 2'd0;
   localparam logic [1:0] RX_PAYLOAD  = 2'd1;
   localparam logic [1:0] RX_SUM_HIGH = 2'd2;
   localparam logic [1:0] RX_SUM_LOW  = 2'd3;

   localparam logic [1:0] TM_NONE    = 2'd0;
   localparam logic [1:0] TM_START   = 2'd1;
   localparam logic [1:0] TM_STOP    = 2'd2;
   localparam logic [1:0] TM_RESTART = 2'd3;

   localparam logic [3:0] ST_OK            = 4'd0;
   localparam logic [3:0] ST_RETRIES       = 4'd1;
   localparam logic [3:0] ST_BAD_IDLE      = 4'd2;
   localparam logic [3:0] ST_UNEXPECTED    = 4'd3;
   localparam logic [3:0] ST_NO_BLOCK      = 4'd4;
   localparam logic [3:0] ST_SHORT         = 4'd5;
   localparam logic [3:0] ST_CHECKSUM_BAD  = 4'd6;
   localparam logic [3:0] ST_NO_REPLY      = 4'd7;
   localparam logic [3:0] ST_NAK           = 4'd8;
   localparam logic [3:0] ST_UNKNOWN_REPLY = 4'd9;
   localparam logic [3:0] ST_INVALID       = 4'd10;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [1:0]  link_phase;
      logic [3:0]  event_count;
      logic [1:0]  rx_part;
      logic [7:0]  block_len;
      logic [7:0]  bytes_taken;
      logic [15:0] running_sum;
      logic [7:0]  sum_high;
   } link_state_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [1:0] timer_cmd;
      logic       send_block;
      logic [3:0] status;
      logic [1:0] link_state;
   } result_type;

   localparam link_state_type LINK_IDLE = '{
      link_phase:  PH_IDLE,
      event_count: 4'd0,
      rx_part:     RX_LENGTH,
      block_len:   8'd0,
      bytes_taken: 8'd0,
      running_sum: 16'd0,
      sum_high:    8'd0
   };

endpackage

// ----- rtl/core/hdbl_in_stage.sv -----
module hdbl_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [7:0]        req_rx_byte,
   input  logic              take,
   output logic              item_valid,
   output hdbl_pkg::item_type item
);
   import hdbl_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   assign req_stall  = valid_ff & ~take;
   assign load       = req_valid & ~req_stall;
   assign valid_in   = load | (valid_ff & ~take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= '{op: req_op, rx_byte: req_rx_byte};
      end
   end

endmodule

// ----- rtl/core/hdbl_step.sv -----
module hdbl_step (
   input  hdbl_pkg::item_type       item,
   input  hdbl_pkg::link_state_type cur,
   input  logic [3:0]               retry_limit,
   output hdbl_pkg::link_state_type nxt,
   output hdbl_pkg::result_type     res
);
   import hdbl_pkg::*;

   logic [3:0]  cnt;
   logic [7:0]  taken_inc;
   logic [15:0] got_sum;
   logic        good;
   logic        txv;
   logic [7:0]  txb;
   logic [1:0]  tmr;
   logic        sblk;
   logic [3:0]  st;

   assign cnt       = (cur.event_count == COUNT_MAX) ? cur.event_count
                                                     : cur.event_count + 4'd1;
   assign taken_inc = cur.bytes_taken + 8'd1;
   assign got_sum   = {cur.sum_high, item.rx_byte};
   assign good      = (got_sum == cur.running_sum);

   always_comb begin
      nxt             = cur;
      nxt.event_count = cnt;
      txv             = 1'b0;
      txb             = 8'h00;
      tmr             = TM_NONE;
      sblk            = 1'b0;
      st              = ST_OK;
      if (item.op == OP_INVALID) begin
         nxt = LINK_IDLE;
         tmr = TM_STOP;
         st  = ST_INVALID;
      end else if (item.op == OP_TIMER && cnt > retry_limit) begin
         nxt = LINK_IDLE;
         tmr = TM_STOP;
         st  = ST_RETRIES;
      end else begin
         if (item.op == OP_BYTE) begin
            nxt.event_count = 4'd0;
         end
         case (cur.link_phase)
            PH_IDLE: begin
               if (item.op == OP_SEND) begin
                  txv            = 1'b1;
                  txb            = CH_ENQ;
                  tmr            = TM_START;
                  nxt.link_phase = PH_WAIT_EOT;
               end else if (item.op == OP_BYTE) begin
                  if (item.rx_byte == CH_ENQ) begin
                     txv            = 1'b1;
                     txb            = CH_EOT;
                     tmr            = TM_START;
                     nxt.link_phase = PH_WAIT_BLOCK;
                     nxt.rx_part    = RX_LENGTH;
                  end else begin
                     st = ST_BAD_IDLE;
                  end
               end else begin
                  nxt = LINK_IDLE;
                  tmr = TM_STOP;
                  st  = ST_INVALID;
               end
            end
            PH_WAIT_EOT: begin
               if (item.op == OP_TIMER) begin
                  txv = 1'b1;
                  txb = CH_ENQ;
               end else if (item.op == OP_BYTE && item.rx_byte == CH_EOT) begin
                  tmr            = TM_RESTART;
                  sblk           = 1'b1;
                  nxt.link_phase = PH_WAIT_CHECK;
               end else begin
                  st = ST_UNEXPECTED;
               end
            end
            PH_WAIT_BLOCK: begin
               if (item.op == OP_TIMER) begin
                  nxt = LINK_IDLE;
                  tmr = TM_STOP;
                  st  = ST_NO_BLOCK;
               end else if (item.op == OP_SEND) begin
                  nxt = LINK_IDLE;
                  tmr = TM_STOP;
               end else begin
                  case (cur.rx_part)
                     RX_LENGTH: begin
                        if (item.rx_byte < MIN_BLOCK_LEN) begin
                           nxt = LINK_IDLE;
                           tmr = TM_STOP;
                           st  = ST_SHORT;
                        end else begin
                           nxt.block_len   = item.rx_byte;
                           nxt.bytes_taken = 8'd0;
                           nxt.running_sum = 16'd0;
                           nxt.rx_part     = RX_PAYLOAD;
                        end
                     end
                     RX_PAYLOAD: begin
                        nxt.running_sum = cur.running_sum + {8'd0, item.rx_byte};
                        nxt.bytes_taken = taken_inc;
                        if (taken_inc >= cur.block_len) begin
                           nxt.rx_part = RX_SUM_HIGH;
                        end
                     end
                     RX_SUM_HIGH: begin
                        nxt.sum_high = item.rx_byte;
                        nxt.rx_part  = RX_SUM_LOW;
                     end
                     default: begin
                        txv = 1'b1;
                        txb = good ? CH_ACK : CH_NAK;
                        st  = good ? ST_OK : ST_CHECKSUM_BAD;
                        nxt = LINK_IDLE;
                        tmr = TM_STOP;
                     end
                  endcase
               end
            end
            default: begin
               if (item.op == OP_TIMER) begin
                  st = ST_NO_REPLY;
               end else if (item.op == OP_BYTE) begin
                  if (item.rx_byte == CH_ACK) begin
                     st = ST_OK;
                  end else if (item.rx_byte == CH_NAK) begin
                     st = ST_NAK;
                  end else begin
                     st = ST_UNKNOWN_REPLY;
                  end
               end
               nxt = LINK_IDLE;
               tmr = TM_STOP;
            end
         endcase
      end
      res = '{tx_valid:   txv,
              tx_byte:    txb,
              timer_cmd:  tmr,
              send_block: sblk,
              status:     st,
              link_state: nxt.link_phase};
   end

endmodule

// ----- rtl/core/half_duplex_block_link_control.sv -----
// Line control for a half-duplex block link: each request is one event (send request,
// received byte, timer expiry or invalid code) and yields exactly one response carrying
// the control byte to transmit, a timer command, the send-block strobe, a status code and
// the link phase after the event. A request is registered on entry, evaluated against the
// link state and written to the response register, so a new request is taken every cycle
// while responses are not stalled; a request passes through the entry register and then
// the response register. Throughput is set only by the response side: while a response is
// stalled the entry register fills and then req_stall rises. The retry limit register
// (reset 3) is written through the csr port, which is always ready, and should be written
// only while no request is in flight.
`include "half_duplex_block_link_control_macros.svh"

module half_duplex_block_link_control (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic [1:0] rsp_timer_cmd,
   output logic       rsp_send_block,
   output logic [3:0] rsp_status,
   output logic [1:0] rsp_link_state,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_retry_limit
);
   import hdbl_pkg::*;

   logic           item_valid;
   item_type       item;
   logic           fire;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [3:0]     retry_limit_ff;
   link_state_type state_ff;
   link_state_type state_in;
   result_type     result_ff;
   result_type     result_in;

   assign csr_ready    = 1'b1;
   assign fire         = item_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   hdbl_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_rx_byte (req_rx_byte),
      .take        (fire),
      .item_valid  (item_valid),
      .item        (item)
   );

   hdbl_step u_step (
      .item        (item),
      .cur         (state_ff),
      .retry_limit (retry_limit_ff),
      .nxt         (state_in),
      .res         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RESET;
         state_ff       <= LINK_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            retry_limit_ff <= csr_retry_limit;
         end
         if (fire) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response while stalled
   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_valid   = result_ff.tx_valid;
   assign rsp_tx_byte    = result_ff.tx_byte;
   assign rsp_timer_cmd  = result_ff.timer_cmd;
   assign rsp_send_block = result_ff.send_block;
   assign rsp_status     = result_ff.status;
   assign rsp_link_state = result_ff.link_state;

   `HDBL_ASSERT_NOW(a_send_block_phase, clock, reset, rsp_valid && rsp_send_block,
      rsp_link_state == PH_WAIT_CHECK && rsp_timer_cmd == TM_RESTART)
   `HDBL_ASSERT_NOW(a_stop_goes_idle, clock, reset, rsp_valid && rsp_timer_cmd == TM_STOP,
      rsp_link_state == PH_IDLE)
   `HDBL_ASSERT_NOW(a_quiet_byte_zero, clock, reset, rsp_valid && !rsp_tx_valid,
      rsp_tx_byte == 8'h00)
   `HDBL_ASSERT_NEXT(a_invalid_clears, clock, reset, fire && item.op == OP_INVALID,
      state_ff == LINK_IDLE && rsp_status == ST_INVALID)

endmodule
